/* src/assert_macros.svh */
// Assertion helpers shared by the navigator RTL.
// Both macros sample on the rising clock edge and are masked while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every sampled edge.
`define ASSERT_SYNC(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Overlapping implication from a trigger condition to a consequence.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

/* src/qpn_pkg.sv */
`default_nettype none

package qpn_pkg;

   // Default favorite capacity of the block.
   localparam int MAX_FAVORITES_DEFAULT = 16;

   // Button level changes are taken only after more than this many milliseconds.
   localparam logic [31:0] DEBOUNCE_MS = 32'd30;

   // Quarter steps per detent, in both directions.
   localparam logic signed [3:0] DETENT_UP = 4'sd4;
   localparam logic signed [3:0] DETENT_DOWN = -4'sd4;

   // Pages that exist regardless of the favorite count.
   localparam int FIXED_PAGES = 3;

   // Page on which detents steer the graph selection.
   localparam int GRAPH_PAGE = 2;

   // Phase after reset: both contacts idle high.
   localparam logic [1:0] PHASE_IDLE = 2'b11;

   // Reciprocal of three for the small page count division.
   localparam logic [11:0] DIV3_MUL = 12'd43;
   localparam int DIV3_SHIFT = 7;

   // Signed quarter step for a move from the previous to the current phase.
   // Moves across both contacts at once count as no step.
   function automatic logic signed [1:0] quarter_step(input logic [1:0] prev_phase,
                                                      input logic [1:0] cur_phase);
      logic [3:0] code;
      logic signed [1:0] step;
      code = {prev_phase, cur_phase};
      case (code)
         4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
         default: step = 2'sd0;
      endcase
      return step;
   endfunction

   // Page count: three fixed pages plus one per started group of three favorites,
   // at least one. The division by three is exact for all 5-bit counts.
   function automatic logic [3:0] page_total(input logic [4:0] fav);
      logic [11:0] prod;
      logic [3:0] groups;
      prod = (12'(fav) + 12'd2) * DIV3_MUL;
      groups = prod[DIV3_SHIFT +: 4];
      if (groups == 4'd0) begin
         groups = 4'd1;
      end
      return 4'(FIXED_PAGES) + groups;
   endfunction

endpackage

`default_nettype wire

/* src/qpn_debounce.sv */
`default_nettype none

`include "assert_macros.svh"

module qpn_debounce
   import qpn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        poll,
   input  wire logic        button_level,
   input  wire logic [31:0] now_ms,
   output logic             press
);

   logic        held_ff;
   logic        held_in;
   logic [31:0] last_ms_ff;
   logic [31:0] last_ms_in;
   logic        pressed;
   logic        take;
   logic [31:0] elapsed;

   // A level change is taken once enough time has passed since the last one.
   always_comb begin
      pressed = ~button_level;
      elapsed = now_ms - last_ms_ff;
      take = poll && (pressed != held_ff) && (elapsed > DEBOUNCE_MS);
      press = take && pressed;
      held_in = take ? pressed : held_ff;
      last_ms_in = take ? now_ms : last_ms_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         last_ms_ff <= 32'd0;
      end else begin
         held_ff <= held_in;
         last_ms_ff <= last_ms_in;
      end
   end

   `ASSERT_IMPLIES(a_take_updates_held, take, ##1 (held_ff == $past(pressed)), "held level not updated")
   `ASSERT_IMPLIES(a_idle_keeps_time, !poll, ##1 $stable(last_ms_ff), "time stamp moved without a poll")
   `ASSERT_IMPLIES(a_press_after_gap, press, elapsed > DEBOUNCE_MS, "press taken inside debounce window")

endmodule

`default_nettype wire

/* src/quadrature_page_navigator_core.sv */
// Data path: a beat taken on req is held in the input register and then in the
// result register, which drives rsp.
// Throughput: one beat per cycle; the input register and result register form a
// two-stage pipeline that stalls only while rsp_tready is low.
// Reset: synchronous, active high; page, selection, quarter count and favorite
// count clear to zero, the phase to both contacts high, and no beat is pending.
`default_nettype none

`include "assert_macros.svh"

module quadrature_page_navigator_core
   import qpn_pkg::*;
#(
   parameter int MAX_FAVORITES = MAX_FAVORITES_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] contact_a, [1] contact_b, [2] button_level, [34:3] now_ms, rest zero
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] page_number, [7:4] graph_choice, [8] redraw, rest zero
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_tvalid,
   output logic             csr_tready,
   // [4:0] favorite_count, rest ignored
   input  wire logic [7:0]  csr_tdata
);

   // The 5-bit register field limits the usable favorite count.
   localparam int FAV_CAP = (MAX_FAVORITES < 31) ? MAX_FAVORITES : 31;
   localparam int FAV_W = $clog2(FAV_CAP + 1);
   localparam int SEL_W = (FAV_CAP > 1) ? $clog2(FAV_CAP) : 1;
   localparam int GROUPS_MAX = ((FAV_CAP + 2) / 3 > 1) ? (FAV_CAP + 2) / 3 : 1;
   localparam int PAGE_MAX = FIXED_PAGES + GROUPS_MAX;
   localparam int PAGE_W = $clog2(PAGE_MAX + 1);

   // Pipeline control.
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [39:0]             in_data_ff;
   logic [39:0]             in_data_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [15:0]             rsp_data_ff;
   logic [15:0]             rsp_data_in;
   logic                    advance;
   logic                    step;
   logic                    csr_fire;

   // Navigation state.
   logic [1:0]              phase_ff;
   logic [1:0]              phase_in;
   logic signed [3:0]       quarter_ff;
   logic signed [3:0]       quarter_in;
   logic [PAGE_W-1:0]       page_ff;
   logic [PAGE_W-1:0]       page_in;
   logic [SEL_W-1:0]        sel_ff;
   logic [SEL_W-1:0]        sel_in;
   logic [FAV_W-1:0]        fav_ff;
   logic [FAV_W-1:0]        fav_in;
   logic [PAGE_W-1:0]       total_ff;
   logic [PAGE_W-1:0]       total_in;

   // Per-beat working values.
   logic [1:0]              cur_phase;
   logic                    moved;
   logic signed [1:0]       qstep;
   logic signed [3:0]       qsum;
   logic                    detent;
   logic                    turn_up;
   logic                    on_graph;
   logic [SEL_W-1:0]        sel_max;
   logic [SEL_W-1:0]        sel_step;
   logic [PAGE_W-1:0]       page_last;
   logic [PAGE_W-1:0]       page_turn;
   logic [PAGE_W-1:0]       page_step;
   logic                    press;
   logic [FAV_W-1:0]        fav_new;
   logic [PAGE_W-1:0]       total_new;
   logic [PAGE_W+3:0]       page_ext;
   logic [SEL_W+3:0]        sel_ext;

   // Handshake: the input register refills whenever its beat moves on.
   always_comb begin
      advance = !rsp_valid_ff || rsp_tready;
      step = in_valid_ff && advance;
      req_tready = !in_valid_ff || advance;
      csr_tready = !in_valid_ff;
      csr_fire = csr_tvalid && csr_tready;
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      in_data_in = (req_tvalid && req_tready) ? req_tdata : in_data_ff;
   end

   qpn_debounce u_debounce (
      .clock        (clock),
      .reset        (reset),
      .poll         (step),
      .button_level (in_data_ff[2]),
      .now_ms       (in_data_ff[34:3]),
      .press        (press)
   );

   // Quarter counting and detent detection.
   always_comb begin
      cur_phase = {in_data_ff[0], in_data_ff[1]};
      moved = cur_phase != phase_ff;
      qstep = quarter_step(phase_ff, cur_phase);
      qsum = quarter_ff + {{2{qstep[1]}}, qstep};
      detent = moved && (qsum == DETENT_UP || qsum == DETENT_DOWN);
      turn_up = !qsum[3];
   end

   // Detent steers the selection on the graph page when favorites exist, the page elsewhere.
   always_comb begin
      on_graph = (page_ff == PAGE_W'(GRAPH_PAGE)) && (fav_ff != '0);
      sel_max = SEL_W'(fav_ff - FAV_W'(1));
      if (turn_up) begin
         sel_step = (sel_ff == sel_max) ? '0 : sel_ff + SEL_W'(1);
      end else begin
         sel_step = (sel_ff == '0) ? sel_max : sel_ff - SEL_W'(1);
      end
      page_last = total_ff - PAGE_W'(1);
      if (!detent || on_graph) begin
         page_turn = page_ff;
      end else if (turn_up) begin
         page_turn = (page_ff == page_last) ? '0 : page_ff + PAGE_W'(1);
      end else begin
         page_turn = (page_ff == '0) ? page_last : page_ff - PAGE_W'(1);
      end
      // A press after the detent always moves one page forward.
      if (press) begin
         page_step = (page_turn == page_last) ? '0 : page_turn + PAGE_W'(1);
      end else begin
         page_step = page_turn;
      end
   end

   // Favorite count write with saturation and range cleanup.
   always_comb begin
      if ({3'b000, csr_tdata[4:0]} > 8'(FAV_CAP)) begin
         fav_new = FAV_W'(FAV_CAP);
      end else begin
         fav_new = FAV_W'(csr_tdata[4:0]);
      end
      total_new = PAGE_W'(page_total(5'(fav_new)));
   end

   // Next state of the navigation registers.
   always_comb begin
      phase_in = phase_ff;
      quarter_in = quarter_ff;
      page_in = page_ff;
      sel_in = sel_ff;
      fav_in = fav_ff;
      total_in = total_ff;
      if (step) begin
         phase_in = cur_phase;
         if (moved) begin
            quarter_in = detent ? 4'sd0 : qsum;
         end
         page_in = page_step;
         if (detent && on_graph) begin
            sel_in = sel_step;
         end
      end else if (csr_fire) begin
         fav_in = fav_new;
         total_in = total_new;
         if (page_ff >= total_new) begin
            page_in = '0;
         end
         if (8'(sel_ff) >= 8'(fav_new)) begin
            sel_in = '0;
         end
      end
   end

   // Result beat assembly.
   always_comb begin
      page_ext = {4'b0000, page_in};
      sel_ext = {4'b0000, sel_in};
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
      rsp_data_in = step ? {7'd0, detent || press, sel_ext[3:0], page_ext[3:0]}
                         : rsp_data_ff;
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata = rsp_data_ff;
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= PHASE_IDLE;
         quarter_ff <= 4'sd0;
         page_ff <= '0;
         sel_ff <= '0;
         fav_ff <= '0;
         total_ff <= PAGE_W'(page_total(5'd0));
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff <= phase_in;
         quarter_ff <= quarter_in;
         page_ff <= page_in;
         sel_ff <= sel_in;
         fav_ff <= fav_in;
         total_ff <= total_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_SYNC(a_page_in_range, page_ff < total_ff, "page beyond page count")
   `ASSERT_SYNC(a_sel_in_range, (fav_ff == '0) ? (sel_ff == '0) : (FAV_W'(sel_ff) < fav_ff), "selection beyond favorites")
   `ASSERT_SYNC(a_quarter_bounded, (quarter_ff < DETENT_UP) && (quarter_ff > DETENT_DOWN), "quarter count left detent range")
   `ASSERT_IMPLIES(a_step_gives_result, step, ##1 rsp_valid_ff, "processed beat produced no result")

endmodule

`default_nettype wire
